@@ src/dsmcc_pkg.sv @@
`timescale 1ns / 1ps

package dsmcc_pkg;

  // Saturation point of the consumed-byte count
  localparam logic [15:0] MAX_SECTION_BYTES = 16'd4096;

  localparam int PHASE_W = 5;

  localparam logic [PHASE_W-1:0] PH_PROTO  = 5'd0;
  localparam logic [PHASE_W-1:0] PH_TYPE   = 5'd1;
  localparam logic [PHASE_W-1:0] PH_MSGID  = 5'd2;
  localparam logic [PHASE_W-1:0] PH_TXID   = 5'd3;
  localparam logic [PHASE_W-1:0] PH_RESV   = 5'd4;
  localparam logic [PHASE_W-1:0] PH_ADLEN  = 5'd5;
  localparam logic [PHASE_W-1:0] PH_MSGLEN = 5'd6;
  localparam logic [PHASE_W-1:0] PH_ADAPT  = 5'd7;
  localparam logic [PHASE_W-1:0] PH_DLID   = 5'd8;
  localparam logic [PHASE_W-1:0] PH_BLK    = 5'd9;
  localparam logic [PHASE_W-1:0] PH_WIN    = 5'd10;
  localparam logic [PHASE_W-1:0] PH_ACK    = 5'd11;
  localparam logic [PHASE_W-1:0] PH_TWIN   = 5'd12;
  localparam logic [PHASE_W-1:0] PH_TSCN   = 5'd13;
  localparam logic [PHASE_W-1:0] PH_CDLEN  = 5'd14;
  localparam logic [PHASE_W-1:0] PH_CDSKIP = 5'd15;
  localparam logic [PHASE_W-1:0] PH_NMOD   = 5'd16;
  localparam logic [PHASE_W-1:0] PH_MID    = 5'd17;
  localparam logic [PHASE_W-1:0] PH_MSIZE  = 5'd18;
  localparam logic [PHASE_W-1:0] PH_MVER   = 5'd19;
  localparam logic [PHASE_W-1:0] PH_MILEN  = 5'd20;
  localparam logic [PHASE_W-1:0] PH_MINFO  = 5'd21;
  localparam logic [PHASE_W-1:0] PH_PLEN   = 5'd22;
  localparam logic [PHASE_W-1:0] PH_PDATA  = 5'd23;
  localparam logic [PHASE_W-1:0] PH_DONE   = 5'd24;
  localparam logic [PHASE_W-1:0] PH_COUNT  = 5'd25;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_DLPARAM = 3'd1;
  localparam logic [2:0] KIND_MODULE  = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_MINFO   = 3'd4;
  localparam logic [2:0] KIND_PRIVATE = 3'd5;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TRAILING  = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [15:0] id_word;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [7:0]  byte_c;
    logic [1:0]  parse_status;
  } rec_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // Byte width of each numeric field; zero for byte-wise phases
  function automatic logic [2:0] field_len(input logic [PHASE_W-1:0] ph);
    logic [2:0] n;
    case (ph)
      PH_PROTO, PH_TYPE, PH_RESV, PH_ADLEN, PH_WIN, PH_ACK,
      PH_MVER, PH_MILEN: n = 3'd1;
      PH_MSGID, PH_MSGLEN, PH_BLK, PH_CDLEN, PH_NMOD, PH_MID,
      PH_PLEN: n = 3'd2;
      PH_TXID, PH_DLID, PH_TWIN, PH_TSCN, PH_MSIZE: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

@@ src/dsmcc_dii_stream_parser.sv @@
`timescale 1ns / 1ps

// Parses the data part of a DSM-CC DownloadInfoIndication section, one byte per
// transfer, with last_byte marking the final byte. Emits a message-header record,
// a download-parameter record, one record per module, one record per module-info
// and private-data byte, and an end record on the final byte whose parse_status
// reports a match, trailing bytes or a truncated section. Each byte passes
// through an input register, the field decoder and a result register, so a byte
// is taken every clock while the result side keeps up. Bytes after the end record
// start a new section.
module dsmcc_dii_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        rec_valid,
  input  logic        rec_ready,
  output logic [2:0]  record_kind,
  output logic [15:0] id_word,
  output logic [31:0] word_a,
  output logic [31:0] word_b,
  output logic [31:0] word_c,
  output logic [7:0]  byte_a,
  output logic [7:0]  byte_b,
  output logic [7:0]  byte_c,
  output logic [1:0]  parse_status
);
  import dsmcc_pkg::*;

  item_t item_in, item_q;
  logic  item_valid, advance, rec_has;
  rec_t  rec_c, rec_q;

  assign item_in = {data_byte, last_byte};

  dsmcc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .item_in    (item_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item_q     (item_q)
  );

  dsmcc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_q),
    .rec_has (rec_has),
    .rec     (rec_c)
  );

  dsmcc_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .advance    (advance),
    .rec_has    (rec_has),
    .rec_in     (rec_c),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec_q      (rec_q)
  );

  assign record_kind  = rec_q.record_kind;
  assign id_word      = rec_q.id_word;
  assign word_a       = rec_q.word_a;
  assign word_b       = rec_q.word_b;
  assign word_c       = rec_q.word_c;
  assign byte_a       = rec_q.byte_a;
  assign byte_b       = rec_q.byte_b;
  assign byte_c       = rec_q.byte_c;
  assign parse_status = rec_q.parse_status;

endmodule

@@ src/dsmcc_in_reg.sv @@
`timescale 1ns / 1ps

module dsmcc_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  output logic               data_ready,
  input  dsmcc_pkg::item_t   item_in,
  input  logic               advance,
  output logic               item_valid,
  output dsmcc_pkg::item_t   item_q
);
  import dsmcc_pkg::*;

  logic item_valid_next;

  assign data_ready = !item_valid || advance;

  always_comb begin
    item_valid_next = item_valid;
    if (advance) item_valid_next = 1'b0;
    if (data_valid && data_ready) item_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) item_q <= item_in;
  end

endmodule

@@ src/dsmcc_core.sv @@
`timescale 1ns / 1ps

module dsmcc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  dsmcc_pkg::item_t  item,
  output logic              rec_has,
  output dsmcc_pkg::rec_t   rec
);
  import dsmcc_pkg::*;

  logic [PHASE_W-1:0] phase, phase_next, phase_eff;
  logic [2:0]  field_idx, field_idx_next, idx_inc;
  logic [31:0] shift, shift_next, shift_v;
  logic [15:0] skip, skip_next, skip_dec;
  logic [15:0] mods_rem, mods_rem_next, mods_dec;
  logic [15:0] mods_decl, mods_decl_next;
  logic [15:0] consumed, consumed_next;
  logic        complete, complete_next;
  logic        was_done;

  // Held field values
  logic [7:0]  proto, proto_next, mtype, mtype_next, adlen, adlen_next;
  logic [15:0] msgid, msgid_next;
  logic [31:0] txid, txid_next;
  logic [31:0] dlid, dlid_next, twin, twin_next;
  logic [15:0] blk, blk_next;
  logic [7:0]  win, win_next, ack, ack_next;
  logic [15:0] mid, mid_next;
  logic [31:0] msize, msize_next;
  logic [7:0]  mver, mver_next;

  always_comb begin
    phase_next     = phase;
    field_idx_next = field_idx;
    shift_next     = shift;
    skip_next      = skip;
    mods_rem_next  = mods_rem;
    mods_decl_next = mods_decl;
    complete_next  = complete;
    proto_next = proto;  mtype_next = mtype;  adlen_next = adlen;
    msgid_next = msgid;  txid_next = txid;
    dlid_next  = dlid;   twin_next = twin;  blk_next = blk;
    win_next   = win;    ack_next  = ack;
    mid_next   = mid;    msize_next = msize;  mver_next = mver;
    rec     = '0;
    rec_has = 1'b0;

    was_done = (phase == PH_DONE);
    phase_eff = (phase >= PH_COUNT) ? PH_DONE : phase;
    consumed_next = (consumed < MAX_SECTION_BYTES) ? consumed + 16'd1 : consumed;
    skip_dec = skip - 16'd1;
    mods_dec = mods_rem - 16'd1;
    shift_v  = {shift[23:0], item.data_byte};
    idx_inc  = field_idx + 3'd1;

    case (phase_eff)
      PH_ADAPT, PH_CDSKIP: begin
        skip_next = skip_dec;
        if (skip_dec == 16'd0) phase_next = (phase_eff == PH_ADAPT) ? PH_DLID : PH_NMOD;
      end
      PH_MINFO: begin
        rec_has = 1'b1;
        rec.record_kind = KIND_MINFO;
        rec.byte_a = item.data_byte;
        skip_next = skip_dec;
        if (skip_dec == 16'd0) begin
          mods_rem_next = mods_dec;
          phase_next = (mods_dec == 16'd0) ? PH_PLEN : PH_MID;
        end
      end
      PH_PDATA: begin
        rec_has = 1'b1;
        rec.record_kind = KIND_PRIVATE;
        rec.byte_a = item.data_byte;
        skip_next = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_next = PH_DONE;
          complete_next = 1'b1;
        end
      end
      PH_DONE: ;
      default: begin
        if (idx_inc >= field_len(phase_eff)) begin
          field_idx_next = 3'd0;
          shift_next = '0;
          case (phase_eff)
            PH_PROTO:  begin proto_next = shift_v[7:0];  phase_next = PH_TYPE;  end
            PH_TYPE:   begin mtype_next = shift_v[7:0];  phase_next = PH_MSGID; end
            PH_MSGID:  begin msgid_next = shift_v[15:0]; phase_next = PH_TXID;  end
            PH_TXID:   begin txid_next  = shift_v;       phase_next = PH_RESV;  end
            PH_RESV:   phase_next = PH_ADLEN;
            PH_ADLEN:  begin adlen_next = shift_v[7:0];  phase_next = PH_MSGLEN; end
            PH_MSGLEN: begin
              rec_has = 1'b1;
              rec.record_kind = KIND_HEADER;
              rec.id_word = msgid;
              rec.word_a  = txid;
              rec.word_b  = {16'd0, shift_v[15:0]};
              rec.byte_a  = proto;
              rec.byte_b  = mtype;
              rec.byte_c  = adlen;
              if (adlen != 8'd0) begin
                skip_next = {8'd0, adlen};
                phase_next = PH_ADAPT;
              end else begin
                phase_next = PH_DLID;
              end
            end
            PH_DLID:   begin dlid_next = shift_v;       phase_next = PH_BLK;  end
            PH_BLK:    begin blk_next  = shift_v[15:0]; phase_next = PH_WIN;  end
            PH_WIN:    begin win_next  = shift_v[7:0];  phase_next = PH_ACK;  end
            PH_ACK:    begin ack_next  = shift_v[7:0];  phase_next = PH_TWIN; end
            PH_TWIN:   begin twin_next = shift_v;       phase_next = PH_TSCN; end
            PH_TSCN: begin
              rec_has = 1'b1;
              rec.record_kind = KIND_DLPARAM;
              rec.id_word = blk;
              rec.word_a  = dlid;
              rec.word_b  = twin;
              rec.word_c  = shift_v;
              rec.byte_a  = win;
              rec.byte_b  = ack;
              phase_next  = PH_CDLEN;
            end
            PH_CDLEN: begin
              // zero descriptor length: only the length bytes are consumed
              if (shift_v[15:0] != 16'd0) begin
                skip_next = shift_v[15:0];
                phase_next = PH_CDSKIP;
              end else begin
                phase_next = PH_NMOD;
              end
            end
            PH_NMOD: begin
              mods_decl_next = shift_v[15:0];
              mods_rem_next  = shift_v[15:0];
              phase_next = (shift_v[15:0] == 16'd0) ? PH_PLEN : PH_MID;
            end
            PH_MID:   begin mid_next   = shift_v[15:0]; phase_next = PH_MSIZE; end
            PH_MSIZE: begin msize_next = shift_v;       phase_next = PH_MVER;  end
            PH_MVER:  begin mver_next  = shift_v[7:0];  phase_next = PH_MILEN; end
            PH_MILEN: begin
              rec_has = 1'b1;
              rec.record_kind = KIND_MODULE;
              rec.id_word = mid;
              rec.word_a  = msize;
              rec.byte_a  = mver;
              rec.byte_b  = shift_v[7:0];
              if (shift_v[7:0] != 8'd0) begin
                skip_next = {8'd0, shift_v[7:0]};
                phase_next = PH_MINFO;
              end else begin
                mods_rem_next = mods_dec;
                phase_next = (mods_dec == 16'd0) ? PH_PLEN : PH_MID;
              end
            end
            PH_PLEN: begin
              if (shift_v[15:0] != 16'd0) begin
                skip_next = shift_v[15:0];
                phase_next = PH_PDATA;
              end else begin
                phase_next = PH_DONE;
                complete_next = 1'b1;
              end
            end
            default: ;
          endcase
        end else begin
          field_idx_next = idx_inc;
          shift_next = shift_v;
        end
      end
    endcase

    // The end record replaces anything this byte produced; then start over
    if (item.last_byte) begin
      rec = '0;
      rec_has = 1'b1;
      rec.record_kind = KIND_END;
      rec.id_word = mods_decl_next;
      rec.word_a  = {16'd0, consumed_next};
      rec.parse_status = was_done ? STATUS_TRAILING :
                         (complete_next ? STATUS_OK : STATUS_TRUNCATED);
      phase_next     = PH_PROTO;
      field_idx_next = 3'd0;
      shift_next     = '0;
      skip_next      = '0;
      mods_rem_next  = '0;
      mods_decl_next = '0;
      consumed_next  = '0;
      complete_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_PROTO;
      field_idx <= 3'd0;
      shift     <= '0;
      skip      <= '0;
      mods_rem  <= '0;
      mods_decl <= '0;
      consumed  <= '0;
      complete  <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      field_idx <= field_idx_next;
      shift     <= shift_next;
      skip      <= skip_next;
      mods_rem  <= mods_rem_next;
      mods_decl <= mods_decl_next;
      consumed  <= consumed_next;
      complete  <= complete_next;
    end
  end

  // Every held field is written before the record that reads it
  always_ff @(posedge clk) begin
    if (advance) begin
      proto <= proto_next;  mtype <= mtype_next;  adlen <= adlen_next;
      msgid <= msgid_next;  txid  <= txid_next;
      dlid  <= dlid_next;   twin  <= twin_next;   blk <= blk_next;
      win   <= win_next;    ack   <= ack_next;
      mid   <= mid_next;    msize <= msize_next;  mver <= mver_next;
    end
  end

endmodule

@@ src/dsmcc_out_reg.sv @@
`timescale 1ns / 1ps

module dsmcc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              advance,
  input  logic              rec_has,
  input  dsmcc_pkg::rec_t   rec_in,
  output logic              rec_valid,
  input  logic              rec_ready,
  output dsmcc_pkg::rec_t   rec_q
);
  import dsmcc_pkg::*;

  logic rec_valid_next;

  // Slot is free when empty or being drained this cycle
  assign advance = item_valid && (!rec_valid || rec_ready);

  always_comb begin
    rec_valid_next = rec_valid;
    if (rec_valid && rec_ready) rec_valid_next = 1'b0;
    if (advance && rec_has) rec_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else begin
      rec_valid <= rec_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && rec_has) rec_q <= rec_in;
  end

endmodule

@@ sim/dii_record_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the DII parser, predicts the record stream from the
// accepted bytes and compares each record, field by field, in order.
module dii_record_checker
  import dsmcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  input  logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        rec_valid,
  input  logic        rec_ready,
  input  logic [2:0]  record_kind,
  input  logic [15:0] id_word,
  input  logic [31:0] word_a,
  input  logic [31:0] word_b,
  input  logic [31:0] word_c,
  input  logic [7:0]  byte_a,
  input  logic [7:0]  byte_b,
  input  logic [7:0]  byte_c,
  input  logic [1:0]  parse_status,
  output int          mismatches,
  output int          outstanding,
  output int          records_checked
);

  rec_t pending_records[$];

  // Parser state as seen from the byte stream
  logic [PHASE_W-1:0] cur_phase;
  logic [2:0]         field_pos;
  logic [31:0]        field_acc;
  logic [7:0]         hdr_proto, hdr_type, hdr_adapt_len;
  logic [15:0]        hdr_msg_id;
  logic [31:0]        hdr_tx_id;
  logic [31:0]        dl_id, dl_win_timeout;
  logic [15:0]        dl_block_size;
  logic [7:0]         dl_win_size, dl_ack_period;
  logic [15:0]        mod_id;
  logic [31:0]        mod_size;
  logic [7:0]         mod_version;
  logic [15:0]        skip_left;
  logic [15:0]        mods_left;
  logic [15:0]        mods_declared;
  logic [15:0]        consumed;
  logic               parse_done;

  function automatic int field_bytes(input logic [PHASE_W-1:0] ph);
    case (ph)
      PH_MSGID, PH_MSGLEN, PH_BLK, PH_CDLEN, PH_NMOD, PH_MID, PH_PLEN: return 2;
      PH_TXID, PH_DLID, PH_TWIN, PH_TSCN, PH_MSIZE: return 4;
      PH_ADAPT, PH_CDSKIP, PH_MINFO, PH_PDATA, PH_DONE: return 0;
      default: return 1;
    endcase
  endfunction

  task automatic clear_parse();
    cur_phase = PH_PROTO;
    field_pos = '0;
    field_acc = '0;
    hdr_proto = '0;
    hdr_type = '0;
    hdr_adapt_len = '0;
    hdr_msg_id = '0;
    hdr_tx_id = '0;
    dl_id = '0;
    dl_win_timeout = '0;
    dl_block_size = '0;
    dl_win_size = '0;
    dl_ack_period = '0;
    mod_id = '0;
    mod_size = '0;
    mod_version = '0;
    skip_left = '0;
    mods_left = '0;
    mods_declared = '0;
    consumed = '0;
    parse_done = 1'b0;
  endtask

  task automatic close_module();
    mods_left = mods_left - 16'd1;
    cur_phase = (mods_left == 16'd0) ? PH_PLEN : PH_MID;
  endtask

  task automatic parse_byte(input logic [7:0] b_in, input logic fin,
                            output logic produced, output rec_t r);
    logic        was_done;
    logic [31:0] v;
    produced = 1'b0;
    r = '0;
    was_done = (cur_phase == PH_DONE);
    if (consumed < MAX_SECTION_BYTES) consumed = consumed + 16'd1;
    if (cur_phase >= PH_COUNT) cur_phase = PH_DONE;

    case (cur_phase)
      PH_ADAPT, PH_CDSKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) cur_phase = (cur_phase == PH_ADAPT) ? PH_DLID : PH_NMOD;
      end
      PH_MINFO: begin
        produced = 1'b1;
        r.record_kind = KIND_MINFO;
        r.byte_a = b_in;
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) close_module();
      end
      PH_PDATA: begin
        produced = 1'b1;
        r.record_kind = KIND_PRIVATE;
        r.byte_a = b_in;
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) begin
          cur_phase = PH_DONE;
          parse_done = 1'b1;
        end
      end
      PH_DONE: ;
      default: begin
        field_acc = {field_acc[23:0], b_in};
        field_pos = field_pos + 3'd1;
        if (field_pos >= field_bytes(cur_phase)) begin
          v = field_acc;
          field_pos = '0;
          field_acc = '0;
          case (cur_phase)
            PH_PROTO: begin hdr_proto = v[7:0]; cur_phase = PH_TYPE; end
            PH_TYPE:  begin hdr_type = v[7:0]; cur_phase = PH_MSGID; end
            PH_MSGID: begin hdr_msg_id = v[15:0]; cur_phase = PH_TXID; end
            PH_TXID:  begin hdr_tx_id = v; cur_phase = PH_RESV; end
            PH_RESV:  cur_phase = PH_ADLEN;
            PH_ADLEN: begin hdr_adapt_len = v[7:0]; cur_phase = PH_MSGLEN; end
            PH_MSGLEN: begin
              produced = 1'b1;
              r.record_kind = KIND_HEADER;
              r.id_word = hdr_msg_id;
              r.word_a = hdr_tx_id;
              r.word_b = {16'd0, v[15:0]};
              r.byte_a = hdr_proto;
              r.byte_b = hdr_type;
              r.byte_c = hdr_adapt_len;
              if (hdr_adapt_len != 8'd0) begin
                skip_left = {8'd0, hdr_adapt_len};
                cur_phase = PH_ADAPT;
              end else begin
                cur_phase = PH_DLID;
              end
            end
            PH_DLID: begin dl_id = v; cur_phase = PH_BLK; end
            PH_BLK:  begin dl_block_size = v[15:0]; cur_phase = PH_WIN; end
            PH_WIN:  begin dl_win_size = v[7:0]; cur_phase = PH_ACK; end
            PH_ACK:  begin dl_ack_period = v[7:0]; cur_phase = PH_TWIN; end
            PH_TWIN: begin dl_win_timeout = v; cur_phase = PH_TSCN; end
            PH_TSCN: begin
              produced = 1'b1;
              r.record_kind = KIND_DLPARAM;
              r.id_word = dl_block_size;
              r.word_a = dl_id;
              r.word_b = dl_win_timeout;
              r.word_c = v;
              r.byte_a = dl_win_size;
              r.byte_b = dl_ack_period;
              cur_phase = PH_CDLEN;
            end
            PH_CDLEN: begin
              // zero descriptor length: nothing beyond the length itself
              if (v[15:0] != 16'd0) begin
                skip_left = v[15:0];
                cur_phase = PH_CDSKIP;
              end else begin
                cur_phase = PH_NMOD;
              end
            end
            PH_NMOD: begin
              mods_declared = v[15:0];
              mods_left = v[15:0];
              cur_phase = (v[15:0] == 16'd0) ? PH_PLEN : PH_MID;
            end
            PH_MID:   begin mod_id = v[15:0]; cur_phase = PH_MSIZE; end
            PH_MSIZE: begin mod_size = v; cur_phase = PH_MVER; end
            PH_MVER:  begin mod_version = v[7:0]; cur_phase = PH_MILEN; end
            PH_MILEN: begin
              produced = 1'b1;
              r.record_kind = KIND_MODULE;
              r.id_word = mod_id;
              r.word_a = mod_size;
              r.byte_a = mod_version;
              r.byte_b = v[7:0];
              if (v[7:0] != 8'd0) begin
                skip_left = {8'd0, v[7:0]};
                cur_phase = PH_MINFO;
              end else begin
                close_module();
              end
            end
            PH_PLEN: begin
              if (v[15:0] != 16'd0) begin
                skip_left = v[15:0];
                cur_phase = PH_PDATA;
              end else begin
                cur_phase = PH_DONE;
                parse_done = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    endcase

    // The end record replaces whatever the final byte produced
    if (fin) begin
      r = '0;
      produced = 1'b1;
      r.record_kind = KIND_END;
      r.id_word = mods_declared;
      r.word_a = {16'd0, consumed};
      r.parse_status = was_done ? STATUS_TRAILING :
                       (parse_done ? STATUS_OK : STATUS_TRUNCATED);
      clear_parse();
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch in %s at record %0d: got %h, expected %h",
             $realtime, what, records_checked, got, want);
    mismatches = mismatches + 1;
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    records_checked = 0;
  end

  always @(posedge clk) begin : watch
    rec_t next_rec;
    rec_t want;
    logic produced;
    if (rst) begin
      clear_parse();
      pending_records.delete();
    end else begin
      if (data_valid && data_ready) begin
        parse_byte(data_byte, last_byte, produced, next_rec);
        if (produced) pending_records = {pending_records, next_rec};
      end
      if (rec_valid && rec_ready) begin
        if (pending_records.size() == 0) begin
          flag_mismatch("record with none pending", {29'd0, record_kind}, '0);
        end else begin
          want = pending_records.pop_front();
          if (record_kind !== want.record_kind)
            flag_mismatch("record_kind", 32'(record_kind), 32'(want.record_kind));
          if (id_word !== want.id_word)
            flag_mismatch("id_word", 32'(id_word), 32'(want.id_word));
          if (word_a !== want.word_a) flag_mismatch("word_a", word_a, want.word_a);
          if (word_b !== want.word_b) flag_mismatch("word_b", word_b, want.word_b);
          if (word_c !== want.word_c) flag_mismatch("word_c", word_c, want.word_c);
          if (byte_a !== want.byte_a)
            flag_mismatch("byte_a", 32'(byte_a), 32'(want.byte_a));
          if (byte_b !== want.byte_b)
            flag_mismatch("byte_b", 32'(byte_b), 32'(want.byte_b));
          if (byte_c !== want.byte_c)
            flag_mismatch("byte_c", 32'(byte_c), 32'(want.byte_c));
          if (parse_status !== want.parse_status)
            flag_mismatch("parse_status", 32'(parse_status), 32'(want.parse_status));
        end
        records_checked = records_checked + 1;
      end
    end
    outstanding <= pending_records.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  localparam int END_EXACT    = 0;
  localparam int END_TRAILING = 1;
  localparam int END_CUT      = 2;

  localparam int RANDOM_BYTES = 1800;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        rec_valid;
  logic        rec_ready = 1'b0;
  logic [2:0]  record_kind;
  logic [15:0] id_word;
  logic [31:0] word_a, word_b, word_c;
  logic [7:0]  byte_a, byte_b, byte_c;
  logic [1:0]  parse_status;

  int mismatches, outstanding, records_checked;

  logic [7:0] section_q[$];
  bit         no_idle = 1'b0;
  int         bytes_sent = 0;
  int         sections = 0;
  int         exact_count = 0, trailing_count = 0, cut_count = 0, noise_count = 0;
  int         ready_hold = 0;
  int         rec_stall;

  always #10 clk = ~clk;

  dsmcc_dii_stream_parser dut (
    .clk, .rst, .data_valid, .data_ready, .data_byte, .last_byte,
    .rec_valid, .rec_ready, .record_kind, .id_word, .word_a, .word_b, .word_c,
    .byte_a, .byte_b, .byte_c, .parse_status
  );

  dii_record_checker u_checker (
    .clk, .rst, .data_valid, .data_ready, .data_byte, .last_byte,
    .rec_valid, .rec_ready, .record_kind, .id_word, .word_a, .word_b, .word_c,
    .byte_a, .byte_b, .byte_c, .parse_status,
    .mismatches, .outstanding, .records_checked
  );

  // Record side: after each transfer, ready may go low for a randomly drawn stall; never with no_idle
  always @(posedge clk) begin
    if (rst) begin
      rec_ready <= 1'b0;
      ready_hold <= 0;
    end else if (rec_valid && rec_ready) begin
      rec_stall = no_idle ? 0 : $urandom_range(0, 4);
      rec_ready <= (rec_stall == 0);
      ready_hold <= rec_stall;
    end else if (ready_hold > 0) begin
      rec_ready <= (ready_hold == 1);
      ready_hold <= ready_hold - 1;
    end else begin
      rec_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b_in, input logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte <= b_in;
    last_byte <= fin;
    @(posedge clk);
    while (!data_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    data_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] field_value(input int fill);
    case (fill)
      FILL_ZERO: return '0;
      FILL_ONES: return '1;
      default:   return $urandom;
    endcase
  endfunction

  task automatic append_byte(input logic [7:0] b_in);
    section_q = {section_q, b_in};
  endtask

  task automatic put_field(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) append_byte(v[8*i +: 8]);
  endtask

  // Lay out a DII data part; a negative info_len draws each module's own
  task automatic build_dii(input int fill, input int adapt_len, input int desc_len,
                           input int n_mod, input int info_len, input int priv_len);
    int milen;
    section_q.delete();
    put_field(field_value(fill), 1);
    put_field(field_value(fill), 1);
    put_field(field_value(fill), 2);
    put_field(field_value(fill), 4);
    put_field(field_value(fill), 1);
    put_field(adapt_len, 1);
    put_field(field_value(fill), 2);
    repeat (adapt_len) put_field(field_value(fill), 1);
    put_field(field_value(fill), 4);
    put_field(field_value(fill), 2);
    put_field(field_value(fill), 1);
    put_field(field_value(fill), 1);
    put_field(field_value(fill), 4);
    put_field(field_value(fill), 4);
    put_field(desc_len, 2);
    repeat (desc_len) put_field(field_value(fill), 1);
    put_field(n_mod, 2);
    repeat (n_mod) begin
      put_field(field_value(fill), 2);
      put_field(field_value(fill), 4);
      put_field(field_value(fill), 1);
      if (info_len >= 0) milen = info_len;
      else milen = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 4);
      put_field(milen, 1);
      repeat (milen) put_field(field_value(fill), 1);
    end
    put_field(priv_len, 2);
    repeat (priv_len) put_field(field_value(fill), 1);
  endtask

  task automatic send_section(input int ending);
    int n_send;
    case (ending)
      END_TRAILING: begin
        repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(0, 255)));
        n_send = section_q.size();
        trailing_count++;
      end
      END_CUT: begin
        n_send = $urandom_range(1, section_q.size() - 1);
        cut_count++;
      end
      default: begin
        n_send = section_q.size();
        exact_count++;
      end
    endcase
    for (int i = 0; i < n_send; i++) send_byte(section_q[i], i == n_send - 1);
    sections++;
  endtask

  initial begin
    int pick;
    int ending;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // A lone final byte: truncated right at the start
    section_q.delete();
    append_byte(8'($urandom_range(0, 255)));
    send_section(END_EXACT);
    // All-zero section: every count zero, zero descriptor length
    build_dii(FILL_ZERO, 0, 0, 0, 0, 0);
    send_section(END_EXACT);
    // All-ones fields, then bytes after completion
    build_dii(FILL_ONES, 1, 0, 1, 0, 0);
    send_section(END_TRAILING);
    // Every loop populated, cut short somewhere inside
    build_dii(FILL_RANDOM, 2, 3, 2, 2, 3);
    send_section(END_CUT);
    wait_drained();

    while (bytes_sent < RANDOM_BYTES) begin
      no_idle = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        section_q.delete();
        repeat ($urandom_range(1, 40)) append_byte(8'($urandom_range(0, 255)));
        noise_count++;
        send_section(END_EXACT);
      end else begin
        build_dii(FILL_RANDOM,
                  ($urandom_range(0, 49) == 0) ? 255 : $urandom_range(0, 3),
                  ($urandom_range(0, 39) == 0) ? 300 :
                  (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6)),
                  $urandom_range(0, 3), -1,
                  ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
        ending = $urandom_range(0, 99);
        send_section(ending < 70 ? END_EXACT : (ending < 85 ? END_TRAILING : END_CUT));
      end
      if (sections % 8 == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d bytes in %0d sections: %0d whole, %0d with trailing bytes,",
             bytes_sent, sections, exact_count, trailing_count);
    $display("%0d cut short, %0d noise; %0d records checked.",
             cut_count, noise_count, records_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
